### sv/micfifo_pkg.sv
package micfifo_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] mode_t;
  typedef logic [7:0] sample_t;
  typedef logic [8:0] level_t;

  localparam cmd_t CMD_RESET = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_FILL  = 2'd2;

  localparam mode_t MODE_PHYSICAL = 2'd0;
  localparam mode_t MODE_INTERNAL = 2'd1;

  localparam int NOISE_LEN = 32;
  localparam int NOISE_IW  = $clog2(NOISE_LEN);

  typedef logic [NOISE_IW-1:0] noise_idx_t;

  // Cyclic noise pattern played back in internal noise mode.
  localparam sample_t NOISE_TABLE [NOISE_LEN] = '{
    8'hFC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hF5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h8E, 8'hFF,
    8'hF4, 8'hE1, 8'hBF, 8'h9A, 8'h71, 8'h58, 8'h5B, 8'h5F,
    8'h62, 8'hC2, 8'h25, 8'h05, 8'h01, 8'h01, 8'h01, 8'h01
  };

endpackage

### sv/micfifo_ram.sv
module micfifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 320
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/micfifo_noise.sv
module micfifo_noise (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  output micfifo_pkg::sample_t  value
);

  import micfifo_pkg::*;

  noise_idx_t idx;
  noise_idx_t idx_next;

  // The index is advanced before use, so the byte shown is the one at idx + 1.
  // The table length is a power of two, so the add wraps by itself.
  assign idx_next = idx + 1'b1;
  assign value    = NOISE_TABLE[idx_next];

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (step) begin
      idx <= idx_next;
    end
  end

endmodule

### sv/mic_sample_fifo_noise_fill.sv
// Emulated microphone sample buffer: a ring of BUFFER_SAMPLES byte samples with
// read and write pointers and a fill count. A command is taken when start is
// high and busy is low; its result (sample and fill_level) appears on the
// outputs for exactly one cycle with done high, and the receiver has no way to
// hold it off, so it must take every result as it comes. A pointer reset, a
// gated read, a fill on a full buffer, a noise fill outside internal mode and
// the unused command code give their result in the cycle after the transfer,
// and busy stays low. A read that passes the gate goes through a read state,
// because the sample memory has a registered read port. A fill writes one
// sample per cycle through the single memory write port until the buffer is
// full. After reset the block sweeps the whole sample memory to zero, one
// entry per cycle, which keeps busy high until the sweep ends; mode writes on
// the configuration channel are taken at any time, including during that
// sweep. The mode register should only be changed while no command is in
// flight.
module mic_sample_fifo_noise_fill #(
  parameter int BUFFER_SAMPLES = 320
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  micfifo_pkg::cmd_t    cmd,
  input  logic                 noise_on,
  input  logic                 button_pressed,
  output logic                 done,
  output micfifo_pkg::sample_t sample,
  output micfifo_pkg::level_t  fill_level,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  micfifo_pkg::mode_t   cfg_data
);

  import micfifo_pkg::*;

  localparam int PW = $clog2(BUFFER_SAMPLES);
  localparam int CW = $clog2(BUFFER_SAMPLES + 1);
  localparam logic [PW-1:0] LAST = PW'(BUFFER_SAMPLES - 1);
  localparam logic [CW-1:0] FULL = CW'(BUFFER_SAMPLES);

  // Sequencer states.
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_FILL  = 2'd3;

  logic [1:0]    state;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [CW-1:0] count;
  mode_t         mode;
  logic          fill_noise;

  logic          accept;
  logic          read_open;

  // Shared pointer advance unit: one incrementer with wrap, used by the
  // clearing sweep, the fill loop and the read.
  logic [PW-1:0] adv_src;
  logic [PW-1:0] adv;

  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  sample_t       ram_wdata;
  sample_t       ram_rdata;

  logic          noise_step;
  sample_t       noise_value;

  logic [PW:0]   ring_sum;
  logic [PW:0]   ring_wrap;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign read_open = (mode == MODE_PHYSICAL) || button_pressed;

  assign adv_src = (state == S_READ) ? rd_ptr : wr_ptr;
  assign adv     = (adv_src == LAST) ? '0 : adv_src + 1'b1;

  assign noise_step = (state == S_FILL) && fill_noise;

  // Memory write port: the clearing sweep and the fill loop write at the write
  // pointer, a pointer reset zeroes the entry at the read pointer.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_ptr;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        if (accept && cmd == CMD_RESET) begin
          ram_we    = 1'b1;
          ram_waddr = rd_ptr;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = fill_noise ? noise_value : '0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  micfifo_ram #(
    .WIDTH ($bits(sample_t)),
    .DEPTH (BUFFER_SAMPLES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  micfifo_noise u_noise (
    .clk   (clk),
    .rst   (rst),
    .step  (noise_step),
    .value (noise_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      count      <= '0;
      mode       <= MODE_PHYSICAL;
      fill_noise <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          // The sweep leaves the write pointer back at zero when it ends.
          wr_ptr <= adv;
          if (wr_ptr == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            sample     <= '0;
            fill_level <= level_t'(count);
            done       <= 1'b1;
            case (cmd)
              CMD_RESET: begin
                wr_ptr     <= rd_ptr;
                count      <= '0;
                fill_level <= '0;
              end
              CMD_READ: begin
                // The memory read is issued at this transfer; data is ready
                // in the next cycle.
                if (read_open) begin
                  done  <= 1'b0;
                  state <= S_READ;
                end
              end
              CMD_FILL: begin
                if (count != FULL && (!noise_on || mode == MODE_INTERNAL)) begin
                  done       <= 1'b0;
                  fill_noise <= noise_on;
                  state      <= S_FILL;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          sample <= ram_rdata;
          done   <= 1'b1;
          state  <= S_IDLE;
          if (count != '0) begin
            rd_ptr     <= adv;
            count      <= count - 1'b1;
            fill_level <= level_t'(count - 1'b1);
          end else begin
            fill_level <= level_t'(count);
          end
        end
        S_FILL: begin
          wr_ptr <= adv;
          count  <= count + 1'b1;
          if (count == FULL - 1'b1) begin
            sample     <= '0;
            fill_level <= level_t'(FULL);
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Expected write pointer from the read pointer and the count, used to check
  // that the ring bookkeeping stays consistent.
  assign ring_sum  = {1'b0, rd_ptr} + (PW + 1)'(count);
  assign ring_wrap = (ring_sum >= (PW + 1)'(BUFFER_SAMPLES)) ?
                     ring_sum - (PW + 1)'(BUFFER_SAMPLES) : ring_sum;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("fill count exceeds buffer size");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (rd_ptr <= LAST) && (wr_ptr <= LAST))
    else $error("pointer outside buffer");

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (wr_ptr == ring_wrap[PW-1:0]))
    else $error("write pointer does not match read pointer plus count");

  a_fill_progress: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |=> (count == $past(count) + 1'b1))
    else $error("fill loop did not add one sample");

endmodule
